>>> hdl/mms_pkg.sv
// shared types, constants and codes of the min-max contrast stretch block
package mms_pkg;

    localparam int NUM_CH     = 3;
    localparam int PIX_BITS   = 8;
    localparam int RANGE_BITS = 8;
    localparam int OUT_BITS   = 8;
    localparam int DIV_STEPS  = OUT_BITS;
    localparam int REG_BITS   = 2;

    // register indexes (byte address bits [3:2])
    localparam logic [REG_BITS-1:0] REG_RANGE_A = 2'd0;
    localparam logic [REG_BITS-1:0] REG_RANGE_B = 2'd1;
    localparam logic [REG_BITS-1:0] REG_RANGE_C = 2'd2;

    localparam logic [RANGE_BITS-1:0] RANGE_RESET = 8'd255;

    typedef logic [NUM_CH-1:0][PIX_BITS-1:0]   t_chans;
    typedef logic [NUM_CH-1:0][RANGE_BITS-1:0] t_ranges;
    typedef logic [NUM_CH-1:0][OUT_BITS-1:0]   t_outs;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic prep;
        logic mul;
        logic div_step;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
    } t_sts;

endpackage

>>> hdl/mms_regs.sv
// range registers behind the apb-style configuration port
module mms_regs
    import mms_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output t_ranges             o_ranges
);

    t_ranges            r_ranges;
    logic [REG_BITS-1:0] w_idx;
    logic               w_wr;

    assign w_idx  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ranges <= {NUM_CH{RANGE_RESET}};
        end else if (w_wr) begin
            case (w_idx)
                REG_RANGE_A: r_ranges[0] <= pwdata[RANGE_BITS-1:0];
                REG_RANGE_B: r_ranges[1] <= pwdata[RANGE_BITS-1:0];
                REG_RANGE_C: r_ranges[2] <= pwdata[RANGE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_RANGE_A: prdata = {{(32-RANGE_BITS){1'b0}}, r_ranges[0]};
            REG_RANGE_B: prdata = {{(32-RANGE_BITS){1'b0}}, r_ranges[1]};
            REG_RANGE_C: prdata = {{(32-RANGE_BITS){1'b0}}, r_ranges[2]};
            default:     prdata = '0;
        endcase
    end

    assign o_ranges = r_ranges;

endmodule

>>> hdl/mms_ctrl.sv
// sequencer: accepts words, steps the datapath through a scale word
module mms_ctrl
    import mms_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_kind,
    input  t_sts i_sts,
    output logic o_ready,
    output t_cmd o_cmd
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
                // measure words finish in the accept cycle
                if (i_valid && i_kind) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/mms_dp.sv
// datapath: min/max tracking, clamp, multiply, restoring divide, output register
module mms_dp
    import mms_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  logic    i_kind,
    input  logic    i_start,
    input  t_chans  i_chans,
    input  t_ranges i_ranges,
    input  logic    i_out_ready,
    output t_sts    o_sts,
    output logic    o_out_valid,
    output t_outs   o_outs
);

    localparam int CB = CHANNEL_BITS;

    logic              r_out_valid;
    t_outs             r_outs;

    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_outs         = r_outs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
        logic [CB+PIX_BITS-1:0] w_ext;
        logic [CB-1:0]          w_v;
        logic [CB-1:0]          r_v, r_min, r_max;
        logic [CB-1:0]          w_clamp;
        logic [CB-1:0]          r_diff, r_den;
        logic                   r_flat;
        logic [CB+RANGE_BITS-1:0] w_prod;
        logic [CB-1:0]          r_rem;
        logic [OUT_BITS-1:0]    r_lo;
        logic [CB:0]            w_trial, w_den_ext;
        logic                   w_ge;

        // only the low channel bits of the pixel are used
        assign w_ext = {{CB{1'b0}}, i_chans[g]};
        assign w_v   = w_ext[CB-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_min <= '1;
                r_max <= '0;
            end else if (i_cmd.accept && !i_kind) begin
                if (i_start) begin
                    r_min <= w_v;
                    r_max <= w_v;
                end else begin
                    if (w_v < r_min) r_min <= w_v;
                    if (w_v > r_max) r_max <= w_v;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.accept) begin
                r_v <= w_v;
            end
        end

        // clamp into [min, max]
        assign w_clamp = (r_v < r_min) ? r_min : ((r_v > r_max) ? r_max : r_v);

        always_ff @(posedge i_clk) begin
            if (i_cmd.prep) begin
                r_diff <= w_clamp - r_min;
                r_den  <= r_max - r_min;
                r_flat <= (r_max <= r_min);
            end
        end

        assign w_prod    = r_diff * i_ranges[g];
        assign w_trial   = {r_rem, r_lo[OUT_BITS-1]};
        assign w_den_ext = {1'b0, r_den};
        assign w_ge      = (w_trial >= w_den_ext);

        // quotient is below 2^OUT_BITS, so the top of the product starts below the divisor
        always_ff @(posedge i_clk) begin
            if (i_cmd.mul) begin
                r_rem <= w_prod[CB+RANGE_BITS-1:RANGE_BITS];
                r_lo  <= w_prod[RANGE_BITS-1:0];
            end else if (i_cmd.div_step) begin
                r_rem <= w_ge ? CB'(w_trial - w_den_ext) : w_trial[CB-1:0];
                r_lo  <= {r_lo[OUT_BITS-2:0], w_ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.emit) begin
                r_outs[g] <= r_flat ? '0 : r_lo;
            end
        end
    end

endmodule

>>> hdl/minmax_stretch_rgb.sv
// top level of the per-channel min-max contrast stretch for three-channel pixels
//
//  channel    dir  handshake                    payload
//  s_axis     in   s_axis_tvalid/s_axis_tready  tdata: chan_a, chan_b, chan_c
//                                               tuser: kind, start_frame
//  m_axis     out  m_axis_tvalid/m_axis_tready  tdata: out_a, out_b, out_c
//  apb        in   psel/penable/pwrite/pready   range_a @0, range_b @4, range_c @8
//
// a measure word updates min/max at the accept edge
// a scale word runs from accept to the next accept through clamp, one
// multiply, then 8 restoring divide steps run in three lanes in parallel
// the result waits in the output register; measure words are still taken
// while it stalls, a scale word is held back only until its result can load
// reset is synchronous: min to all ones, max to zero, ranges to 255
module minmax_stretch_rgb
    import mms_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // chan_a[7:0], chan_b[15:8], chan_c[23:16]
    input  logic [1:0]  s_axis_tuser,   // kind[0], start_frame[1]
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_a[7:0], out_b[15:8], out_c[23:16]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cmd    w_cmd;
    t_sts    w_sts;
    t_ranges w_ranges;
    t_outs   w_outs;
    logic    w_kind;
    logic    w_start;

    assign w_kind  = s_axis_tuser[0];
    assign w_start = s_axis_tuser[1];

    // range registers
    mms_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_ranges (w_ranges)
    );

    // sequencer
    mms_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_kind  (w_kind),
        .i_sts   (w_sts),
        .o_ready (s_axis_tready),
        .o_cmd   (w_cmd)
    );

    // arithmetic lanes and output register
    mms_dp #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_kind      (w_kind),
        .i_start     (w_start),
        .i_chans     (t_chans'(s_axis_tdata)),
        .i_ranges    (w_ranges),
        .i_out_ready (m_axis_tready),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .o_outs      (w_outs)
    );

    assign m_axis_tdata = w_outs;

    // a scale word keeps the input closed until its result is formed
    a_scale_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && w_kind) |=> !s_axis_tready)
        else $error("input open straight after a scale word");

    // a measure word never closes the input
    a_measure_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !w_kind) |=> s_axis_tready)
        else $error("input closed after a measure word");

    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> !(m_axis_tvalid && !m_axis_tready))
        else $error("result loaded over a stalled word");

    // output valid only rises after an emit
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_cmd.emit))
        else $error("output valid without an emit");

endmodule
